FILE: rtl/indexed_array_list_defines.svh
// assertion macros for the indexed array list rtl
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef INDEXED_ARRAY_LIST_DEFINES_SVH
`define INDEXED_ARRAY_LIST_DEFINES_SVH

// same-cycle implication
`define IAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/iax_pkg.sv
// shared types and constants for the indexed array list
// no dependencies
package iax_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int CMD_W  = 3;
    localparam int RPOS_W = 6;
    localparam int EXT_W  = 32;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [EXT_W-1:0]      t_ext;
    typedef logic [IDX_W-1:0]      t_index;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [RPOS_W-1:0]     t_rpos;
    typedef logic [CMP_W-1:0]      t_cmp;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_GET    = 3'd3,
        CMD_UPDATE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        COP_HOLD,
        COP_INSERT,
        COP_DELETE,
        COP_UPDATE
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    // broadcast from the control to every cell
    typedef struct packed {
        t_cell_op op;
        t_pos     pos;
        t_word    data;
        t_count   count;
    } t_cell_ctrl;

endpackage

FILE: rtl/iax_cell.sv
// one list cell: holds an entry, shifts with its neighbours, compares and selects
// depends on iax_pkg
module iax_cell (
    input  logic               i_clk,
    input  iax_pkg::t_cell_ctrl i_ctrl,
    input  iax_pkg::t_index    i_index,
    input  iax_pkg::t_word     i_left,
    input  iax_pkg::t_word     i_right,
    output iax_pkg::t_word     o_value,
    output logic               o_match,
    output iax_pkg::t_word     o_pick
);

    iax_pkg::t_word r_value;
    iax_pkg::t_word n_value;
    iax_pkg::t_cmp  w_idx;
    iax_pkg::t_cmp  w_pos;
    iax_pkg::t_cmp  w_cnt;

    assign w_idx = iax_pkg::t_cmp'(i_index);
    assign w_pos = iax_pkg::t_cmp'(i_ctrl.pos);
    assign w_cnt = iax_pkg::t_cmp'(i_ctrl.count);

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            iax_pkg::COP_INSERT: begin
                if (w_idx > w_pos) begin
                    n_value = i_left;
                end else if (w_idx == w_pos) begin
                    n_value = i_ctrl.data;
                end
            end
            iax_pkg::COP_DELETE: begin
                if (w_idx >= w_pos) begin
                    n_value = i_right;
                end
            end
            iax_pkg::COP_UPDATE: begin
                if (w_idx == w_pos) begin
                    n_value = i_ctrl.data;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_ctrl.data) && (w_idx < w_cnt);
    assign o_pick  = (w_idx == w_pos) ? r_value : '0;

endmodule

FILE: rtl/iax_first_match.sv
// lowest set position of the registered match vector
// depends on iax_pkg
module iax_first_match (
    input  logic [iax_pkg::DEPTH-1:0] i_match,
    output logic                      o_found,
    output iax_pkg::t_index           o_index
);

    always_comb begin
        o_index = '0;
        for (int i = iax_pkg::DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_index = iax_pkg::t_index'(i);
            end
        end
    end

    assign o_found = |i_match;

endmodule

FILE: rtl/indexed_array_list.sv
// indexed array list top level: control, chain of list cells, result register
// depends on iax_pkg, iax_cell, iax_first_match and indexed_array_list_defines.svh
//
// channel   direction  tuser            tdata
// s_axis    in         command          position, data_in
// m_axis    out        status           result_position, result_data, entry_count
//
// a command passes through accept, cell update and compare, then result load
// find resolves the first match in the result cycle from the registered match bits
// a new command is taken while an earlier result still waits at the output
// the result cycle stalls while the output register is full and not taken
// reset clears the count and control; entries need no reset
module indexed_array_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // position[6:0], data_in[38:7], pad
    input  logic [2:0]  i_s_axis_tuser,   // command[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // result_position[5:0], result_data[37:6],
                                          // entry_count[44:38], pad
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    `include "indexed_array_list_defines.svh"

    iax_pkg::t_state  r_state;
    iax_pkg::t_state  n_state;
    iax_pkg::t_cmd    r_cmd;
    iax_pkg::t_pos    r_pos;
    iax_pkg::t_word   r_data;
    iax_pkg::t_count  r_count;
    iax_pkg::t_count  n_count;
    iax_pkg::t_status r_status;
    iax_pkg::t_word   r_get;
    logic [iax_pkg::DEPTH-1:0] r_match;

    logic              r_out_valid;
    iax_pkg::t_status  r_out_status;
    iax_pkg::t_rpos    r_out_rpos;
    iax_pkg::t_ext     r_out_data;
    iax_pkg::t_count   r_out_count;

    logic              w_accept;
    logic              w_exec;
    logic              w_load;
    logic              w_do_ins;
    logic              w_do_del;
    logic              w_do_upd;
    logic              w_get_ok;
    iax_pkg::t_status  w_status;
    iax_pkg::t_cell_ctrl w_ctrl;
    iax_pkg::t_cmp     w_pos;
    iax_pkg::t_cmp     w_cnt;
    iax_pkg::t_word    w_get;
    logic              w_found;
    iax_pkg::t_index   w_first;
    iax_pkg::t_status  w_res_status;
    iax_pkg::t_rpos    w_res_rpos;

    iax_pkg::t_word            w_value [iax_pkg::DEPTH];
    iax_pkg::t_word            w_pick  [iax_pkg::DEPTH];
    logic [iax_pkg::DEPTH-1:0] w_match;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iax_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = iax_pkg::ST_EXEC;
                end
            end
            iax_pkg::ST_EXEC: begin
                n_state = iax_pkg::ST_DONE;
            end
            iax_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = iax_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iax_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_exec          = 1'b0;
        w_load          = 1'b0;
        case (r_state)
            iax_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            iax_pkg::ST_EXEC: begin
                w_exec = 1'b1;
            end
            iax_pkg::ST_DONE: begin
                w_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pos    = iax_pkg::t_cmp'(r_pos);
    assign w_cnt    = iax_pkg::t_cmp'(r_count);

    // bounds checks
    always_comb begin
        w_status = iax_pkg::STAT_OK;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        w_do_upd = 1'b0;
        w_get_ok = 1'b0;
        case (r_cmd)
            iax_pkg::CMD_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = iax_pkg::STAT_RANGE;
                end else if (r_count == iax_pkg::t_count'(iax_pkg::DEPTH)) begin
                    w_status = iax_pkg::STAT_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            iax_pkg::CMD_DELETE: begin
                if (w_pos >= w_cnt) begin
                    w_status = iax_pkg::STAT_RANGE;
                end else begin
                    w_do_del = 1'b1;
                end
            end
            iax_pkg::CMD_FIND: begin
                w_status = iax_pkg::STAT_MISSING;
            end
            iax_pkg::CMD_GET: begin
                if (w_pos >= w_cnt) begin
                    w_status = iax_pkg::STAT_RANGE;
                end else begin
                    w_get_ok = 1'b1;
                end
            end
            iax_pkg::CMD_UPDATE: begin
                if (w_pos >= w_cnt) begin
                    w_status = iax_pkg::STAT_RANGE;
                end else begin
                    w_do_upd = 1'b1;
                end
            end
            default: begin
                w_status = iax_pkg::STAT_RANGE;
            end
        endcase
    end

    always_comb begin
        w_ctrl.op = iax_pkg::COP_HOLD;
        if (w_exec && w_do_ins) begin
            w_ctrl.op = iax_pkg::COP_INSERT;
        end else if (w_exec && w_do_del) begin
            w_ctrl.op = iax_pkg::COP_DELETE;
        end else if (w_exec && w_do_upd) begin
            w_ctrl.op = iax_pkg::COP_UPDATE;
        end
        w_ctrl.pos   = r_pos;
        w_ctrl.data  = r_data;
        w_ctrl.count = r_count;
    end

    always_comb begin
        n_count = r_count;
        if (w_exec && w_do_ins) begin
            n_count = r_count + 1'b1;
        end else if (w_exec && w_do_del) begin
            n_count = r_count - 1'b1;
        end
    end

    // cell chain
    for (genvar g = 0; g < iax_pkg::DEPTH; g++) begin : g_cell
        iax_pkg::t_word w_left;
        iax_pkg::t_word w_right;

        if (g == 0) begin : g_first
            assign w_left = w_value[g];
        end else begin : g_inner_l
            assign w_left = w_value[g-1];
        end

        if (g == iax_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_inner_r
            assign w_right = w_value[g+1];
        end

        iax_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (iax_pkg::t_index'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g]),
            .o_match (w_match[g]),
            .o_pick  (w_pick[g])
        );
    end

    always_comb begin
        w_get = '0;
        for (int i = 0; i < iax_pkg::DEPTH; i++) begin
            w_get = w_get | w_pick[i];
        end
    end

    iax_first_match u_first (
        .i_match (r_match),
        .o_found (w_found),
        .o_index (w_first)
    );

    always_comb begin
        w_res_status = r_status;
        w_res_rpos   = r_pos[iax_pkg::RPOS_W-1:0];
        if (r_cmd == iax_pkg::CMD_FIND) begin
            w_res_status = w_found ? iax_pkg::STAT_OK : iax_pkg::STAT_MISSING;
            w_res_rpos   = w_found ? iax_pkg::t_rpos'(w_first) : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iax_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= iax_pkg::t_cmd'(i_s_axis_tuser);
            r_pos  <= i_s_axis_tdata[6:0];
            r_data <= iax_pkg::t_word'(i_s_axis_tdata[38:7]);
        end
        if (w_exec) begin
            r_status <= w_status;
            r_match  <= w_match;
            r_get    <= w_get_ok ? w_get : '0;
        end
        if (w_load) begin
            r_out_status <= w_res_status;
            r_out_rpos   <= w_res_rpos;
            r_out_data   <= iax_pkg::t_ext'(r_get);
            r_out_count  <= r_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'b000, r_out_count, r_out_data, r_out_rpos};

    `IAL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= iax_pkg::t_count'(iax_pkg::DEPTH), "count above depth")
    `IAL_ASSERT_NEXT(a_insert_grows, w_exec && w_do_ins, r_count == $past(r_count) + 1'b1, "insert did not grow count")
    `IAL_ASSERT_NOW(a_find_in_list, r_state == iax_pkg::ST_DONE && r_cmd == iax_pkg::CMD_FIND && w_found, iax_pkg::t_cmp'(w_first) < w_cnt, "match beyond count")
    `IAL_ASSERT_NEXT(a_result_waits, r_state == iax_pkg::ST_DONE && r_out_valid && !i_m_axis_tready, r_state == iax_pkg::ST_DONE, "result overwrote pending word")

endmodule
